// ===== rtl/msdf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package msdf_pkg;

  localparam int SAMPLE_W = 10;
  localparam int SUM_W    = 16;
  localparam int FILT_W   = 11;

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  localparam logic ST_OK        = 1'b0;
  localparam logic ST_NOT_READY = 1'b1;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [SUM_W-1:0]    sum_t;

  typedef struct packed {
    logic               status;
    logic [FILT_W-1:0]  filtered;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/msdf_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module msdf_cell
  import msdf_pkg::*;
#(
  parameter int INIT_LEVEL = 0
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    shift_en,
  input  wire sample_t d,
  output sample_t      q
);

  sample_t q_r;
  sample_t q_nxt;

  always_comb begin
    q_nxt = q_r;
    if (shift_en) begin
      q_nxt = d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= SAMPLE_W'(INIT_LEVEL);
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

`default_nettype wire

// ===== rtl/msdf_obuf.sv =====
`timescale 1ns / 1ps
`default_nettype none

module msdf_obuf
  import msdf_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire result_t push_data,
  output logic         space,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_data
);

  logic    out_valid_r, out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t out_data_r, out_data_nxt;
  result_t skid_data_r, skid_data_nxt;
  logic    pop;

  assign pop = out_valid_r && out_ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (pop || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push;
        out_data_nxt  = push_data;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign space     = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without head entry");

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !skid_valid_r)
    else $error("push into full output buffer");

  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !out_valid_r) |=> (out_valid_r && out_data_r == $past(push_data)))
    else $error("pushed result lost");

endmodule

`default_nettype wire

// ===== rtl/moving_sum_decimating_filter_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake            payload
// in        in   in_tvalid/in_tready  tuser: action; tdata: sample
// out       out  out_tvalid/out_tready tuser: status; tdata: filtered
//
// One item per cycle while in_tready is high; a sample shifts the cell chain
// and updates the sum, a read's result is registered into the output buffer
// and shown on out once any result ahead of it is taken. Reset: synchronous,
// clears the chain to INIT_LEVEL. A two-entry output buffer takes a read while
// a result waits; in_tready drops only when both entries are held.

module moving_sum_decimating_filter_unit
  import msdf_pkg::*;
#(
  parameter int WINDOW          = 16,
  parameter int AVG_SAMPLES     = 4,
  parameter int OVERSAMPLE_BITS = 1,
  parameter int INIT_LEVEL      = 0
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [9:0] sample
  input  wire logic [0:0]  in_tuser,   // [0] action
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [10:0] filtered
  output logic [0:0]       out_tuser   // [0] status
);

  localparam int POS_W = $clog2(WINDOW);
  localparam int DIV   = AVG_SAMPLES << OVERSAMPLE_BITS;
  localparam logic [63:0] RECIP64 = ((64'd1 << 32) + 64'(DIV) - 64'd1) / 64'(DIV);
  localparam logic [32:0] RECIP   = RECIP64[32:0];
  localparam sum_t SUM_INIT = SUM_W'((INIT_LEVEL * WINDOW) % 65536);

  logic       xfer, is_sample, is_read;
  sample_t    smp;
  sample_t    chain [WINDOW];
  sample_t    oldest;

  logic [POS_W-1:0] pos_r, pos_nxt;
  sum_t             sum_r, sum_nxt;
  logic             fresh_r, fresh_nxt;

  logic [48:0] prod;
  result_t     res;
  logic        space;
  result_t     out_res;

  assign xfer      = in_tvalid && in_tready;
  assign is_sample = xfer && (in_tuser[0] == ACT_SAMPLE);
  assign is_read   = xfer && (in_tuser[0] == ACT_READ);
  assign smp       = in_tdata[SAMPLE_W-1:0];
  assign in_tready = space;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    msdf_cell #(
      .INIT_LEVEL(INIT_LEVEL)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (is_sample),
      .d        ((i == 0) ? smp : chain[(i == 0) ? 0 : i-1]),
      .q        (chain[i])
    );
  end

  assign oldest = chain[WINDOW-1];

  always_comb begin
    pos_nxt   = pos_r;
    sum_nxt   = sum_r;
    fresh_nxt = fresh_r;
    if (is_sample) begin
      sum_nxt = sum_r + SUM_W'(smp) - SUM_W'(oldest);
      if (pos_r == POS_W'(WINDOW-1)) begin
        pos_nxt   = '0;
        fresh_nxt = 1'b1;
      end else begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end else if (is_read) begin
      fresh_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      sum_r   <= SUM_INIT;
      fresh_r <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      sum_r   <= sum_nxt;
      fresh_r <= fresh_nxt;
    end
  end

  // sum / (AVG_SAMPLES << OVERSAMPLE_BITS) by reciprocal, exact for 16-bit sums
  assign prod = 49'(sum_r) * 49'(RECIP);

  always_comb begin
    if (fresh_r) begin
      res.status   = ST_OK;
      res.filtered = prod[32 +: FILT_W];
    end else begin
      res.status   = ST_NOT_READY;
      res.filtered = '0;
    end
  end

  msdf_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (is_read),
    .push_data (res),
    .space     (space),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  assign out_tdata = {{(16-FILT_W){1'b0}}, out_res.filtered};
  assign out_tuser = out_res.status;

  a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
    is_read |=> !fresh_r)
    else $error("fresh flag survived a read");

  a_wrap_sets: assert property (@(posedge clk) disable iff (!rst_n)
    (is_sample && pos_r == POS_W'(WINDOW-1)) |=> (fresh_r && pos_r == '0))
    else $error("wrap did not mark fresh window");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(WINDOW-1))
    else $error("write position out of range");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import msdf_pkg::*;

  localparam int WINDOW          = 16;
  localparam int AVG_SAMPLES     = 4;
  localparam int OVERSAMPLE_BITS = 1;
  localparam int INIT_LEVEL      = 0;
  localparam int POS_W           = $clog2(WINDOW);
  localparam int RANDOM_ITEMS    = 1800;
  localparam int RX_HOLD_CYCLES  = 300;
  localparam int MAX_GAP         = 13;
  localparam int TIMEOUT_NS      = 2_000_000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic [0:0]  out_tuser;

  moving_sum_decimating_filter_unit #(
    .WINDOW          (WINDOW),
    .AVG_SAMPLES     (AVG_SAMPLES),
    .OVERSAMPLE_BITS (OVERSAMPLE_BITS),
    .INIT_LEVEL      (INIT_LEVEL)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // filter state mirror
  sample_t           ring_mirror [WINDOW];
  logic [POS_W-1:0]  wr_pos;
  sum_t              window_sum;
  logic              window_fresh;

  result_t           pending_readouts[$];
  int                mismatch_count = 0;
  int                items_sent = 0;
  bit                tx_idle = 1'b1;
  bit                rx_idle = 1'b1;
  bit                rx_hold_pending = 1'b0;

  function automatic void reset_filter_mirror();
    for (int i = 0; i < WINDOW; i++) ring_mirror[i] = sample_t'(INIT_LEVEL);
    wr_pos       = '0;
    window_sum   = sum_t'(INIT_LEVEL * WINDOW);
    window_fresh = 1'b0;
  endfunction

  // update the mirror for one transfer; a read queues its readout
  function automatic void apply_filter_item(logic action, sample_t smp);
    result_t     res;
    int unsigned quot;
    if (action == ACT_SAMPLE) begin
      window_sum = window_sum + sum_t'(smp) - sum_t'(ring_mirror[wr_pos]);
      ring_mirror[wr_pos] = smp;
      if (wr_pos == POS_W'(WINDOW - 1)) begin
        wr_pos       = '0;
        window_fresh = 1'b1;
      end else begin
        wr_pos = wr_pos + 1'b1;
      end
    end else begin
      if (window_fresh) begin
        quot         = (int'(window_sum) / AVG_SAMPLES) >> OVERSAMPLE_BITS;
        res.status   = ST_OK;
        res.filtered = quot[FILT_W-1:0];
        window_fresh = 1'b0;
      end else begin
        res.status   = ST_NOT_READY;
        res.filtered = '0;
      end
      pending_readouts.push_back(res);
    end
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return sample_t'($urandom_range(0, 1023));
    endcase
  endfunction

  task automatic send_item(logic action, sample_t smp);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid   <= 1'b1;
    in_tuser[0] <= action;
    in_tdata    <= {6'b0, smp};
    do @(posedge clk); while (!(in_tvalid && in_tready));
    apply_filter_item(action, smp);
    items_sent++;
  endtask

  task automatic drain_readouts();
    in_tvalid <= 1'b0;
    while (pending_readouts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // readout checker
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_readouts.size() == 0) begin
        $error("unexpected readout: status=%0d filtered=%0d", out_tuser[0], out_tdata[10:0]);
        mismatch_count++;
      end else begin
        want = pending_readouts.pop_front();
        if (out_tuser[0] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tuser[0]);
          mismatch_count++;
        end
        if (out_tdata[FILT_W-1:0] !== want.filtered) begin
          $error("filtered: expected %0d, got %0d", want.filtered, out_tdata[FILT_W-1:0]);
          mismatch_count++;
        end
      end
    end
  end

  // readout sink
  initial begin
    int unsigned gap;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (rx_hold_pending) begin
        out_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold_pending = 1'b0;
      end
      gap = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  task automatic test_read_before_fill();
    send_item(ACT_READ, '0);
  endtask

  task automatic test_full_scale_window();
    for (int i = 0; i < WINDOW; i++) send_item(ACT_SAMPLE, '1);
    send_item(ACT_READ, '0);
    send_item(ACT_READ, '0);
  endtask

  task automatic test_partial_window();
    for (int i = 0; i < 4; i++) send_item(ACT_SAMPLE, '0);
    send_item(ACT_READ, '0);
  endtask

  // sink stalls while reads keep coming: output buffer fills, in_tready drops
  task automatic test_output_backpressure();
    tx_idle = 1'b0;
    rx_hold_pending = 1'b1;
    for (int i = 0; i < 40; i++) begin
      if (i % 5 == 0) send_item(ACT_SAMPLE, pick_sample());
      else send_item(ACT_READ, '0);
    end
    drain_readouts();
  endtask

  task automatic test_random_traffic();
    int start;
    int seg;
    int n;
    start = items_sent;
    seg   = 0;
    while (items_sent - start < RANDOM_ITEMS) begin
      if ((items_sent - start) / 150 != seg) begin
        seg = (items_sent - start) / 150;
        tx_idle = seg[0];
        rx_idle = seg[1];
      end
      if ($urandom_range(0, 9) < 8) begin
        // run of samples, mostly whole windows, followed by readout(s)
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40)
                                        : WINDOW * $urandom_range(1, 2);
        for (int i = 0; i < n; i++) send_item(ACT_SAMPLE, pick_sample());
        n = $urandom_range(1, 2);
        for (int i = 0; i < n; i++) send_item(ACT_READ, sample_t'($urandom_range(0, 1023)));
      end else begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
          send_item(logic'($urandom_range(0, 1)), pick_sample());
      end
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    reset_filter_mirror();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_read_before_fill();
    test_full_scale_window();
    test_partial_window();
    drain_readouts();
    test_output_backpressure();
    test_random_traffic();
    drain_readouts();

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
